FILE: hw/rtl/tensor_axis_reduce_sum_macros.svh
// Assertion macros used by the reduce-sum back end (tars_back).
`ifndef TENSOR_AXIS_REDUCE_SUM_MACROS_SVH
`define TENSOR_AXIS_REDUCE_SUM_MACROS_SVH

// The condition must never hold while out of reset.
`define TARS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TARS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/tars_pkg.sv
`timescale 1ns / 1ps

package tars_pkg;

    localparam int NUM_DIMS   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int SUM_W      = 48;
    localparam int WORD_W     = SUM_W + 1;
    localparam int CMD_QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_RANK      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_ZERO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_THREE = 3'd5;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [SUM_W-1:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_MIN = 48'h8000_0000_0000;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] element_value;
        logic [9:0]         out_index;
    } tars_req_t;

    typedef struct packed {
        logic signed [47:0] sum_value;
        logic               saturated;
    } tars_rsp_t;

    typedef struct packed {
        logic op;
        logic oor;
    } tars_ctl_t;

endpackage

FILE: hw/rtl/tars_ram.sv
`timescale 1ns / 1ps

module tars_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/tars_fifo.sv
`timescale 1ns / 1ps

module tars_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != (PTR_W + 1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/tars_front.sv
`timescale 1ns / 1ps

module tars_front
    import tars_pkg::*;
#(
    parameter int MAX_RANK  = 4,
    parameter int OUT_DEPTH = 1024,
    parameter int DIM_BITS  = 12,
    localparam int NAXES  = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS,
    localparam int ADDR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  tars_req_t             req,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  busy,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output tars_ctl_t             cmd_ctl,
    output logic [31:0]           cmd_value,
    output logic [ADDR_W-1:0]     cmd_addr
);

    localparam int EW = DIM_BITS + 1;
    localparam int PW = ADDR_W + DIM_BITS + 2;

    logic [2:0]            rank_reg;
    logic [3:0]            mask_reg;
    logic [CFG_DATA_W-1:0] dim_reg [NUM_DIMS];

    logic [DIM_BITS-1:0] coord_reg [NAXES];

    logic [2:0]    eff_rank;
    logic [EW-1:0] ext [NAXES];
    logic          in_rank [NAXES];
    logic          keep [NAXES];
    logic          used_any;
    logic          wrap [NAXES];
    logic          step [NAXES];
    logic          carry;

    logic              adv, accept, cfg_hit;

    logic              st_valid_reg [NAXES];
    logic              st_op_reg    [NAXES];
    logic              st_oor_reg   [NAXES];
    logic [ADDR_W-1:0] st_addr_reg  [NAXES];
    logic [31:0]       st_value_reg [NAXES];
    logic [DIM_BITS-1:0] st_coord_reg [NAXES][NAXES];

    logic              src_op    [NAXES];
    logic              src_oor   [NAXES];
    logic [ADDR_W-1:0] src_addr  [NAXES];
    logic [31:0]       src_value [NAXES];
    logic [DIM_BITS-1:0] src_coord [NAXES][NAXES];
    logic [PW-1:0]     prod      [NAXES];
    logic              st_oor_next  [NAXES];
    logic [ADDR_W-1:0] st_addr_next [NAXES];

    assign adv       = !st_valid_reg[NAXES-1] || cmd_ready;
    assign req_ready = adv && !busy;
    assign accept    = req_valid && req_ready;
    assign cfg_hit   = cfg_we && (cfg_index == CFG_RANK || cfg_index == CFG_AXIS_MASK ||
                       cfg_index == CFG_DIM_ZERO || cfg_index == CFG_DIM_ONE ||
                       cfg_index == CFG_DIM_TWO || cfg_index == CFG_DIM_THREE);

    assign cmd_valid   = st_valid_reg[NAXES-1];
    assign cmd_ctl.op  = st_op_reg[NAXES-1];
    assign cmd_ctl.oor = st_oor_reg[NAXES-1];
    assign cmd_value   = st_value_reg[NAXES-1];
    assign cmd_addr    = st_addr_reg[NAXES-1];

    always_comb
    begin
        if (rank_reg == 3'd0)
        begin
            eff_rank = 3'd1;
        end
        else if (32'(rank_reg) > NAXES)
        begin
            eff_rank = 3'(NAXES);
        end
        else
        begin
            eff_rank = rank_reg;
        end

        used_any = 1'b0;
        for (int k = 0; k < NAXES; k++)
        begin
            in_rank[k] = (k < 32'(eff_rank));
            used_any   = used_any | (in_rank[k] & mask_reg[k]);
            if (dim_reg[k] == '0)
            begin
                ext[k] = EW'(1);
            end
            else if (32'(dim_reg[k]) > (32'(1) << DIM_BITS))
            begin
                ext[k] = EW'(32'(1) << DIM_BITS);
            end
            else
            begin
                ext[k] = EW'(dim_reg[k]);
            end
        end
        for (int k = 0; k < NAXES; k++)
        begin
            keep[k] = used_any && in_rank[k] && !mask_reg[k];
        end

        carry = 1'b1;
        for (int k = NAXES - 1; k >= 0; k--)
        begin
            wrap[k] = (EW'(coord_reg[k]) + EW'(1)) >= ext[k];
            step[k] = in_rank[k] && carry;
            if (in_rank[k])
            begin
                carry = carry & wrap[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NAXES; k++)
        begin
            if (k == 0)
            begin
                src_op[k]    = req.opcode;
                src_value[k] = req.element_value;
                for (int j = 0; j < NAXES; j++)
                begin
                    src_coord[k][j] = coord_reg[j];
                end
                if (req.opcode == OP_READ)
                begin
                    src_addr[k] = ADDR_W'(req.out_index);
                    src_oor[k]  = (32'(req.out_index) >= OUT_DEPTH);
                end
                else
                begin
                    src_addr[k] = '0;
                    src_oor[k]  = 1'b0;
                end
            end
            else
            begin
                src_op[k]    = st_op_reg[k-1];
                src_value[k] = st_value_reg[k-1];
                src_addr[k]  = st_addr_reg[k-1];
                src_oor[k]   = st_oor_reg[k-1];
                for (int j = 0; j < NAXES; j++)
                begin
                    src_coord[k][j] = st_coord_reg[k-1][j];
                end
            end

            prod[k] = PW'(src_addr[k]) * PW'(ext[k]) + PW'(src_coord[k][k]);

            if (src_op[k] == OP_ACCUM && keep[k] && !src_oor[k])
            begin
                st_oor_next[k]  = (64'(prod[k]) >= 64'(OUT_DEPTH));
                st_addr_next[k] = prod[k][ADDR_W-1:0];
            end
            else
            begin
                st_oor_next[k]  = src_oor[k];
                st_addr_next[k] = src_addr[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= 3'd4;
            mask_reg <= '0;
            for (int k = 0; k < NUM_DIMS; k++)
            begin
                dim_reg[k] <= CFG_DATA_W'(1);
            end
            for (int k = 0; k < NAXES; k++)
            begin
                coord_reg[k]    <= '0;
                st_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RANK:      rank_reg   <= cfg_data[2:0];
                    CFG_AXIS_MASK: mask_reg   <= cfg_data[3:0];
                    CFG_DIM_ZERO:  dim_reg[0] <= cfg_data;
                    CFG_DIM_ONE:   dim_reg[1] <= cfg_data;
                    CFG_DIM_TWO:   dim_reg[2] <= cfg_data;
                    CFG_DIM_THREE: dim_reg[3] <= cfg_data;
                    default:       ;
                endcase
            end

            if (cfg_hit)
            begin
                for (int k = 0; k < NAXES; k++)
                begin
                    coord_reg[k] <= '0;
                end
            end
            else if (accept && req.opcode == OP_ACCUM)
            begin
                for (int k = 0; k < NAXES; k++)
                begin
                    if (step[k])
                    begin
                        coord_reg[k] <= wrap[k] ? '0 : coord_reg[k] + 1'b1;
                    end
                end
            end

            if (adv)
            begin
                for (int k = 0; k < NAXES; k++)
                begin
                    st_valid_reg[k] <= (k == 0) ? accept : st_valid_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NAXES; k++)
            begin
                st_op_reg[k]    <= src_op[k];
                st_value_reg[k] <= src_value[k];
                st_oor_reg[k]   <= st_oor_next[k];
                st_addr_reg[k]  <= st_addr_next[k];
                for (int j = 0; j < NAXES; j++)
                begin
                    st_coord_reg[k][j] <= src_coord[k][j];
                end
            end
        end
    end

endmodule

FILE: hw/rtl/tars_back.sv
`timescale 1ns / 1ps
`include "tensor_axis_reduce_sum_macros.svh"

module tars_back
    import tars_pkg::*;
#(
    parameter int OUT_DEPTH = 1024,
    localparam int ADDR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  tars_ctl_t         cmd_ctl,
    input  logic [31:0]       cmd_value,
    input  logic [ADDR_W-1:0] cmd_addr,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tars_rsp_t         rsp,
    output logic              busy
);

    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic              b_valid_reg, b_valid_next;
    logic              b_op_reg;
    logic              b_oor_reg;
    logic [ADDR_W-1:0] b_addr_reg;
    logic [31:0]       b_value_reg;

    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [WORD_W-1:0] fwd_data_reg;

    logic              rsp_valid_reg, rsp_valid_next;
    tars_rsp_t         rsp_reg;

    logic              out_free, b_fire, b_free, a_fire;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] old_word;
    logic [SUM_W:0]    sum_wide;
    logic              ovf;
    logic [SUM_W-1:0]  new_sum;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign b_fire    = b_valid_reg && (b_op_reg == OP_ACCUM || out_free);
    assign b_free    = !b_valid_reg || b_fire;
    assign cmd_ready = b_free && !clearing_reg;
    assign a_fire    = cmd_valid && cmd_ready;
    assign busy      = clearing_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    tars_ram #(
        .WIDTH (WORD_W),
        .DEPTH (OUT_DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (a_fire),
        .raddr (cmd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        old_word = (fwd_valid_reg && fwd_addr_reg == b_addr_reg) ? fwd_data_reg : ram_rdata;
        sum_wide = {old_word[SUM_W-1], old_word[SUM_W-1:0]} +
                   {{(SUM_W + 1 - 32){b_value_reg[31]}}, b_value_reg};
        ovf      = sum_wide[SUM_W] ^ sum_wide[SUM_W-1];
        if (ovf)
        begin
            new_sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            new_sum = sum_wide[SUM_W-1:0];
        end

        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = b_fire && !b_oor_reg;
            ram_waddr = b_addr_reg;
            ram_wdata = (b_op_reg == OP_READ) ? '0 : {old_word[SUM_W] | ovf, new_sum};
        end

        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            if (32'(clr_cnt_reg) == OUT_DEPTH - 1)
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end

        b_valid_next = a_fire ? 1'b1 : (b_fire ? 1'b0 : b_valid_reg);

        if (b_fire && b_op_reg == OP_READ)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && !rsp_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            b_valid_reg   <= b_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ram_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_op_reg    <= cmd_ctl.op;
            b_oor_reg   <= cmd_ctl.oor;
            b_addr_reg  <= cmd_addr;
            b_value_reg <= cmd_value;
        end
        if (ram_we)
        begin
            fwd_addr_reg <= ram_waddr;
            fwd_data_reg <= ram_wdata;
        end
        if (b_fire && b_op_reg == OP_READ)
        begin
            if (b_oor_reg)
            begin
                rsp_reg.sum_value <= '0;
                rsp_reg.saturated <= 1'b0;
            end
            else
            begin
                rsp_reg.sum_value <= old_word[SUM_W-1:0];
                rsp_reg.saturated <= old_word[SUM_W];
            end
        end
    end

    `TARS_ASSERT_NEVER(a_no_issue_while_clearing, clk, rst_n, a_fire && clearing_reg, "command issued during store clearing")
    `TARS_ASSERT_NEVER(a_no_op_while_clearing, clk, rst_n, b_valid_reg && clearing_reg, "command in flight during store clearing")
    `TARS_ASSERT_NEXT(a_fwd_tracks_write, clk, rst_n, ram_we, fwd_valid_reg && fwd_addr_reg == $past(ram_waddr) && fwd_data_reg == $past(ram_wdata), "forward register missed a store write")
    `TARS_ASSERT_NEXT(a_read_loses_no_result, clk, rst_n, rsp_valid_reg && !rsp_ready, rsp_valid_reg && rsp_reg == $past(rsp_reg), "pending result overwritten")

endmodule

FILE: hw/rtl/tensor_axis_reduce_sum.sv
`timescale 1ns / 1ps
//  Channel | Signals                                  | Word
//  --------+------------------------------------------+---------------------------------
//  req     | req_valid, req_ready, req                | opcode, element_value, out_index
//  rsp     | rsp_valid, rsp_ready, rsp                | sum_value, saturated
//  cfg     | cfg_we, cfg_index, cfg_data              | register index and value
//
//  One word is accepted per cycle when nothing stalls; the accumulator RAM does one
//  read-modify-write per cycle, with a forward of the last write covering back-to-back hits.
//  A read word returns its result after min(MAX_RANK, 4) index stages, the queue and the
//  back end's command and result registers; accumulate words give no result.
//  After reset the block clears every word of its store, with req_ready held low meanwhile.
//  A stalled rsp fills the queue and then holds req_ready low; nothing is dropped.

module tensor_axis_reduce_sum
    import tars_pkg::*;
#(
    parameter int MAX_RANK  = 4,
    parameter int OUT_DEPTH = 1024,
    parameter int DIM_BITS  = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  tars_req_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output tars_rsp_t             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CMD_W  = 2 + 32 + ADDR_W;

    logic              busy;
    logic              f_valid, f_ready;
    tars_ctl_t         f_ctl;
    logic [31:0]       f_value;
    logic [ADDR_W-1:0] f_addr;

    logic              q_valid, q_ready;
    logic [CMD_W-1:0]  q_data;
    tars_ctl_t         q_ctl;
    logic [31:0]       q_value;
    logic [ADDR_W-1:0] q_addr;

    tars_front #(
        .MAX_RANK  (MAX_RANK),
        .OUT_DEPTH (OUT_DEPTH),
        .DIM_BITS  (DIM_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_ctl   (f_ctl),
        .cmd_value (f_value),
        .cmd_addr  (f_addr)
    );

    tars_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_ctl, f_value, f_addr}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign {q_ctl, q_value, q_addr} = q_data;

    tars_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_ctl   (q_ctl),
        .cmd_value (q_value),
        .cmd_addr  (q_addr),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .busy      (busy)
    );

endmodule
